@@ hw/rtl/pcf_pkg.sv @@
// Shared types, widths, codes and the coefficient decode for the POT FIR filter.
package pcf_pkg;

    localparam int IDX_W    = 8;
    localparam int COEFF_W  = 32;
    localparam int MAG_W    = 16;
    localparam int SAMPLE_W = 16;
    localparam int CEFF_W   = MAG_W + 1;
    localparam int PROD_W   = SAMPLE_W + CEFF_W;
    localparam int OUT_W    = 40;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic vld;
        logic tap_ok;
        logic first;
        logic last;
    } t_rd_tag;

    typedef struct packed {
        t_rd_tag tag;
        logic    push;
    } t_mac_ctrl;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_mac_stat;

    // Signed-digit weight: magnitude bits with a clear sign bit count +2^b,
    // with a set sign bit -2^b.
    function automatic logic signed [CEFF_W-1:0] pot_coeff(input logic [COEFF_W-1:0] w);
        logic [MAG_W-1:0] pos;
        logic [MAG_W-1:0] neg;
        pos = w[MAG_W-1:0] & ~w[COEFF_W-1:MAG_W];
        neg = w[MAG_W-1:0] &  w[COEFF_W-1:MAG_W];
        return signed'({1'b0, pos}) - signed'({1'b0, neg});
    endfunction

endpackage

@@ hw/rtl/pcf_in_if.sv @@
// Input channel: load and sample beats with valid/ready handshake.
interface pcf_in_if import pcf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [IDX_W-1:0]           tap_index;
    logic [COEFF_W-1:0]         coeff_word;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, op, tap_index, coeff_word, sample, input ready);
    modport sink   (input valid, op, tap_index, coeff_word, sample, output ready);
endinterface

@@ hw/rtl/pcf_out_if.sv @@
// Output channel: filter result beats with valid/ready handshake.
interface pcf_out_if import pcf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] filtered;

    modport source (output valid, filtered, input ready);
    modport sink   (input valid, filtered, output ready);
endinterface

@@ hw/rtl/pcf_ram.sv @@
// Simple dual-port synchronous RAM, one write port, one registered read port.
module pcf_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/pcf_seq.sv @@
// Sequencer: accepts beats, writes the memories and walks the taps one per cycle.
module pcf_seq import pcf_pkg::*; #(
    parameter int TAPS = 256,
    parameter int AW   = 8,
    parameter int FW   = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pcf_in_if.sink              i_in,
    input  t_mac_stat           i_stat,
    output logic                o_cw_en,
    output logic [AW-1:0]       o_cw_addr,
    output logic [COEFF_W-1:0]  o_cw_data,
    output logic                o_hw_en,
    output logic [AW-1:0]       o_hw_addr,
    output logic [SAMPLE_W-1:0] o_hw_data,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_c_raddr,
    output logic [AW-1:0]       o_h_raddr,
    output t_mac_ctrl           o_ctrl
);

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_ptr;
    logic [FW-1:0] r_fill;
    logic [AW-1:0] r_k;
    logic [AW-1:0] r_haddr;
    t_rd_tag       r_tag;

    logic accept;
    logic k_last;
    logic idx_ok;

    assign accept = i_in.valid && i_in.ready;
    assign k_last = (r_k == AW'(TAPS - 1));
    assign idx_ok = (32'(i_in.tap_index) < 32'(TAPS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid && i_in.op == OP_SAMPLE) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (k_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_stat.done) n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = 1'b0;
        o_rd_en     = 1'b0;
        o_ctrl.tag  = r_tag;
        o_ctrl.push = 1'b0;
        unique case (r_state)
            ST_IDLE:  i_in.ready  = 1'b1;
            ST_RUN:   o_rd_en     = 1'b1;
            ST_DRAIN: ;
            ST_HOLD:  o_ctrl.push = i_stat.out_free;
            default:  ;
        endcase
    end

    assign o_cw_en   = accept && (i_in.op == OP_LOAD) && idx_ok;
    assign o_cw_addr = AW'(i_in.tap_index);
    assign o_cw_data = i_in.coeff_word;
    assign o_hw_en   = accept && (i_in.op == OP_SAMPLE);
    assign o_hw_addr = r_ptr;
    assign o_hw_data = i_in.sample;
    assign o_c_raddr = r_k;
    assign o_h_raddr = r_haddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ptr   <= '0;
            r_fill  <= '0;
            r_tag   <= '0;
        end else begin
            r_state   <= n_state;
            r_tag.vld <= o_rd_en;
            if (o_hw_en) begin
                r_ptr <= (r_ptr == AW'(TAPS - 1)) ? '0 : r_ptr + 1'b1;
                if (r_fill != FW'(TAPS)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (o_rd_en) begin
                r_tag.tap_ok <= (FW'(r_k) < r_fill);
                r_tag.first  <= (r_k == '0);
                r_tag.last   <= k_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_hw_en) begin
            r_k     <= '0;
            r_haddr <= r_ptr;
        end else if (o_rd_en) begin
            r_k     <= r_k + 1'b1;
            r_haddr <= (r_haddr == '0) ? AW'(TAPS - 1) : r_haddr - 1'b1;
        end
    end

endmodule

@@ hw/rtl/pcf_mac.sv @@
// Multiply-accumulate datapath and output register.
module pcf_mac import pcf_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_mac_ctrl                  i_ctrl,
    input  logic [COEFF_W-1:0]         i_coeff,
    input  logic signed [SAMPLE_W-1:0] i_hist,
    pcf_out_if.source                  o_out,
    output t_mac_stat                  o_stat
);

    logic signed [CEFF_W-1:0] coef;
    logic signed [PROD_W-1:0] prod;
    logic signed [OUT_W-1:0]  prod_ext;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pvld;
    logic                     r_pfirst;
    logic                     r_plast;
    logic signed [OUT_W-1:0]  r_acc;
    logic                     r_done;
    logic                     r_out_vld;
    logic signed [OUT_W-1:0]  r_out;

    assign coef     = pot_coeff(i_coeff);
    assign prod     = PROD_W'(i_hist) * PROD_W'(coef);
    assign prod_ext = OUT_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld    <= 1'b0;
            r_done    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_pvld <= i_ctrl.tag.vld;
            r_done <= r_pvld && r_plast;
            if (i_ctrl.push) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.tag.vld) begin
            r_prod   <= i_ctrl.tag.tap_ok ? prod : '0;
            r_pfirst <= i_ctrl.tag.first;
            r_plast  <= i_ctrl.tag.last;
        end
        if (r_pvld) begin
            r_acc <= r_pfirst ? prod_ext : r_acc + prod_ext;
        end
        if (i_ctrl.push) begin
            r_out <= r_acc;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.filtered  = r_out;
    assign o_stat.done     = r_done;
    assign o_stat.out_free = !r_out_vld || o_out.ready;

endmodule

@@ hw/rtl/pot_coefficient_fir_filter_core.sv @@
// Top level of the power-of-two coefficient FIR filter.
//
// Input channel i_in carries two kinds of beat. op = load writes coeff_word
// into coefficient slot tap_index (slots at or beyond TAPS are dropped).
// op = sample enters sample into the history ring and produces one 40-bit
// wrapped sum on o_out.
// Each sample walks all TAPS taps, one coefficient and one history word per
// cycle through the read ports of the two RAMs into a single 16x17
// multiplier. A sample's result turns valid after the last tap has passed
// the RAM read, product and accumulator registers and the output register
// frees; i_in takes no new beat before then, but does from that cycle on.
// Reset clears the history pointer and the history fill count; history
// slots not yet filled count as zero. Coefficient slots hold no reset value
// and must be loaded before use.
// The result sits in an output register. While o_out is stalled the next
// beat is still accepted and its sum computed; it then waits until the
// register frees before the block takes another beat.
module pot_coefficient_fir_filter_core import pcf_pkg::*; #(
    parameter int TAPS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcf_in_if.sink    i_in,
    pcf_out_if.source o_out
);

    localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int FW = $clog2(TAPS + 1);

    logic                cw_en;
    logic [AW-1:0]       cw_addr;
    logic [COEFF_W-1:0]  cw_data;
    logic                hw_en;
    logic [AW-1:0]       hw_addr;
    logic [SAMPLE_W-1:0] hw_data;
    logic                rd_en;
    logic [AW-1:0]       c_raddr;
    logic [AW-1:0]       h_raddr;
    logic [COEFF_W-1:0]  c_rdata;
    logic [SAMPLE_W-1:0] h_rdata;
    t_mac_ctrl           ctrl;
    t_mac_stat           stat;

    pcf_seq #(
        .TAPS (TAPS),
        .AW   (AW),
        .FW   (FW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_stat    (stat),
        .o_cw_en   (cw_en),
        .o_cw_addr (cw_addr),
        .o_cw_data (cw_data),
        .o_hw_en   (hw_en),
        .o_hw_addr (hw_addr),
        .o_hw_data (hw_data),
        .o_rd_en   (rd_en),
        .o_c_raddr (c_raddr),
        .o_h_raddr (h_raddr),
        .o_ctrl    (ctrl)
    );

    pcf_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .DW    (COEFF_W)
    ) u_coeff_ram (
        .i_clk   (i_clk),
        .i_we    (cw_en),
        .i_waddr (cw_addr),
        .i_wdata (cw_data),
        .i_re    (rd_en),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    pcf_ram #(
        .DEPTH (TAPS),
        .AW    (AW),
        .DW    (SAMPLE_W)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (hw_en),
        .i_waddr (hw_addr),
        .i_wdata (hw_data),
        .i_re    (rd_en),
        .i_raddr (h_raddr),
        .o_rdata (h_rdata)
    );

    pcf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_coeff (c_rdata),
        .i_hist  (signed'(h_rdata)),
        .o_out   (o_out),
        .o_stat  (stat)
    );

endmodule

@@ tb/pot_coefficient_fir_filter_core_test.sv @@
// Self-checking testbench for the power-of-two coefficient FIR filter core.
module pot_coefficient_fir_filter_core_test import pcf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS         = 256;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_BEATS = 730;
    localparam int HOLD_CYCLES  = 3000;
    localparam int LIMIT_CYCLES = 1_500_000;

    typedef struct packed {
        logic                       op;
        logic [IDX_W-1:0]           tap_index;
        logic [COEFF_W-1:0]         coeff_word;
        logic signed [SAMPLE_W-1:0] sample;
    } t_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                       drv_valid = 1'b0;
    logic                       drv_op    = OP_LOAD;
    logic [IDX_W-1:0]           drv_tap   = '0;
    logic [COEFF_W-1:0]         drv_word  = '0;
    logic signed [SAMPLE_W-1:0] drv_sample = '0;
    logic                       mon_ready = 1'b0;

    pcf_in_if  in_if ();
    pcf_out_if out_if ();

    assign in_if.valid      = drv_valid;
    assign in_if.op         = drv_op;
    assign in_if.tap_index  = drv_tap;
    assign in_if.coeff_word = drv_word;
    assign in_if.sample     = drv_sample;
    assign out_if.ready     = mon_ready;

    pot_coefficient_fir_filter_core #(.TAPS(TAPS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_beat                   pending_beats[$];
    logic signed [OUT_W-1:0] expected_sums[$];

    logic [COEFF_W-1:0]         coeff_bank [TAPS];
    logic signed [SAMPLE_W-1:0] sample_ring[TAPS];
    int                         ring_head = 0;

    int errors      = 0;
    int loads_seen  = 0;
    int samples_fed = 0;
    int sums_checked = 0;
    int beats_sent  = 0;
    int send_gap    = 0;
    int recv_stall  = 0;
    int hold_left   = 0;

    initial begin
        for (int i = 0; i < TAPS; i++) begin
            sample_ring[i] = '0;
        end
    end

    function automatic int draw_gap(input bit calm);
        if (calm) begin
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(signed'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [COEFF_W-1:0] draw_coeff();
        logic [MAG_W-1:0] bit_one;
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h0000_ffff;
            3: return 32'hffff_0000;
            4: begin
                bit_one = 16'h1 << $urandom_range(0, 15);
                return {($urandom_range(0, 1) != 0) ? bit_one : 16'h0, bit_one};
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic add_load(input int slot, input logic [COEFF_W-1:0] word);
        t_beat b;
        b.op         = OP_LOAD;
        b.tap_index  = IDX_W'(slot);
        b.coeff_word = word;
        b.sample     = SAMPLE_W'($urandom);
        pending_beats.insert(pending_beats.size(), b);
    endtask

    task automatic add_sample(input logic signed [SAMPLE_W-1:0] s);
        t_beat b;
        b.op         = OP_SAMPLE;
        b.tap_index  = IDX_W'($urandom);
        b.coeff_word = $urandom;
        b.sample     = s;
        pending_beats.insert(pending_beats.size(), b);
    endtask

    // Signed-digit walk per tap: add or subtract the scaled sample per
    // magnitude bit, then arithmetic shift right; sum wraps to 40 bits.
    task automatic accumulate_taps(input logic signed [SAMPLE_W-1:0] s);
        longint signed total;
        longint signed scaled;
        longint signed acc;
        logic [COEFF_W-1:0] w;
        total = 0;
        sample_ring[ring_head] = s;
        for (int k = 0; k < TAPS; k++) begin
            w      = coeff_bank[k];
            scaled = longint'(sample_ring[(ring_head + TAPS - k) % TAPS]) <<< 16;
            acc    = 0;
            for (int b = 0; b < MAG_W; b++) begin
                if (w[b] && !w[MAG_W + b]) begin
                    acc += scaled;
                end else if (w[b] && w[MAG_W + b]) begin
                    acc -= scaled;
                end
                acc = acc >>> 1;
            end
            total += acc;
        end
        ring_head = (ring_head + 1) % TAPS;
        expected_sums.insert(expected_sums.size(), total[OUT_W-1:0]);
    endtask

    // Input driver
    always @(posedge i_clk) begin
        t_beat b;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            if (drv_valid && in_if.ready) begin
                if (drv_op == OP_LOAD) begin
                    if (int'(drv_tap) < TAPS) begin
                        coeff_bank[drv_tap] = drv_word;
                    end
                    loads_seen++;
                end else begin
                    accumulate_taps(drv_sample);
                    samples_fed++;
                end
                beats_sent++;
                send_gap = draw_gap(((beats_sent / 128) % 3) == 2);
            end
            if (!drv_valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    drv_valid <= 1'b0;
                end else if (pending_beats.size() != 0) begin
                    b = pending_beats.pop_front();
                    drv_op     <= b.op;
                    drv_tap    <= b.tap_index;
                    drv_word   <= b.coeff_word;
                    drv_sample <= b.sample;
                    drv_valid  <= 1'b1;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and scoreboard
    always @(posedge i_clk) begin
        logic signed [OUT_W-1:0] want;
        if (!i_rst_n) begin
            mon_ready <= 1'b0;
        end else begin
            if (out_if.valid && mon_ready) begin
                if (expected_sums.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat, expected none, actual %0d",
                             $time, out_if.filtered);
                end else begin
                    want = expected_sums.pop_front();
                    if (out_if.filtered !== want) begin
                        errors++;
                        $display("%0t: filtered mismatch, expected %0d, actual %0d",
                                 $time, want, out_if.filtered);
                    end
                end
                sums_checked++;
                recv_stall = draw_gap(((sums_checked / 64) % 3) == 1);
                if (sums_checked == 40 || sums_checked == 400) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                mon_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                mon_ready <= 1'b0;
            end else begin
                mon_ready <= 1'b1;
            end
        end
    end

    initial begin
        int added;
        int burst;

        // every slot is written before the first sample reads it
        for (int i = 0; i < TAPS; i++) begin
            case (i)
                0:       add_load(i, 32'h0000_ffff);
                1:       add_load(i, 32'hffff_ffff);
                2:       add_load(i, 32'hffff_0000);
                3:       add_load(i, 32'h0000_0000);
                4:       add_load(i, 32'h0000_8001);
                TAPS-1:  add_load(i, 32'h0000_ffff);
                default: add_load(i, draw_coeff());
            endcase
        end

        add_sample(16'sh7fff);
        add_sample(-16'sh8000);
        add_sample(16'sh0000);
        add_sample(-16'sh0001);
        add_sample(16'sh0001);
        add_load(0, 32'hffff_ffff);
        add_sample(16'sh7fff);
        add_load(TAPS-1, 32'h8000_8000);
        add_load(1, 32'h0000_0001);
        add_sample(-16'sh8000);
        add_sample(-16'sh8000);
        add_sample(-16'sh8000);
        add_load(128, 32'haaaa_5555);
        add_sample(16'sh5555);
        add_sample(-16'sh5556);
        add_load(2, 32'h5555_ffff);
        add_sample(16'sh7fff);
        add_sample(16'sh0000);

        added = 0;
        while (added < RANDOM_BEATS) begin
            if ($urandom_range(0, 3) != 0) begin
                burst = $urandom_range(1, 12);
                for (int i = 0; i < burst; i++) begin
                    add_sample(draw_sample());
                end
            end else begin
                burst = $urandom_range(1, 4);
                for (int i = 0; i < burst; i++) begin
                    add_load($urandom_range(0, TAPS - 1), draw_coeff());
                end
            end
            added += burst;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || drv_valid || expected_sums.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAPS + 40) @(posedge i_clk);

        $display("run covered %0d coefficient loads and %0d samples, %0d sums checked",
                 loads_seen, samples_fed, sums_checked);
        $display("history ring wrapped %0d times; output held off twice for %0d cycles",
                 samples_fed / TAPS, HOLD_CYCLES);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/pcf_pkg.sv
hw/rtl/pcf_in_if.sv
hw/rtl/pcf_out_if.sv
hw/rtl/pcf_ram.sv
hw/rtl/pcf_seq.sv
hw/rtl/pcf_mac.sv
hw/rtl/pot_coefficient_fir_filter_core.sv
tb/pot_coefficient_fir_filter_core_test.sv
